### sv/bcda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcda_pkg: shared types and constants
// Window statistics record passed from the accumulator to the finish unit.
// ----------------------------------------------------------------------------
package bcda_pkg;
  localparam int MAX_BLOCK_SIDE_DEF = 64;
  localparam int SUM_W = 28;
  localparam int SQ_W = 44;
  localparam int CNT_W = 17;
  localparam logic [2:0] REG_BW = 3'd0;
  localparam logic [2:0] REG_BH = 3'd1;
  localparam logic [2:0] REG_FLAT = 3'd2;
  localparam logic [2:0] REG_EDGE = 3'd3;
  localparam logic [2:0] REG_HEAD = 3'd4;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic [CNT_W-1:0] cnt;
  } win_stat_t;
endpackage

### sv/bcda_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcda_accum: front end
// Accepts pixels, forms luma, accumulates sums; emits one record per window.
// ----------------------------------------------------------------------------
module bcda_accum
  import bcda_pkg::*;
#(
  parameter int MAX_BLOCK_SIDE = MAX_BLOCK_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [6:0]  block_width,
  input  logic [6:0]  block_height,
  output logic        st_valid,
  input  logic        st_ready,
  output win_stat_t   st_data
);
  localparam int SW = $clog2(MAX_BLOCK_SIDE + 1);

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             lv_r;
  logic [15:0]      luma_r;
  logic             st_valid_r;
  win_stat_t        st_r;
  logic [SW-1:0]    ww, wh;
  logic [CNT_W-1:0] wn;
  logic             take;

  function automatic logic [SW-1:0] side(input logic [6:0] s);
    if (s < 7'd3) return SW'(3);
    else if (32'(s) > MAX_BLOCK_SIDE) return SW'(MAX_BLOCK_SIDE);
    else return SW'(s);
  endfunction

  assign ww = side(block_width);
  assign wh = side(block_height);
  assign wn = CNT_W'(ww * wh);

  // stall intake only while a finished record waits
  assign in_tready = !st_valid_r || st_ready;
  assign take = in_tvalid && in_tready;

  // stage 1: luma
  always_ff @(posedge clk) begin
    if (!rst_n) lv_r <= 1'b0;
    else if (in_tready) lv_r <= take;
    if (take)
      luma_r <= 16'(in_tdata[7:0]) * 16'd77 + 16'(in_tdata[15:8]) * 16'd150
              + 16'(in_tdata[23:16]) * 16'd29;
  end

  // stage 2: accumulate
  always_comb begin
    sum_nxt = sum_r + SUM_W'(luma_r);
    sq_nxt  = sq_r + SQ_W'(32'(luma_r) * 32'(luma_r));
    cnt_nxt = cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0; sq_r <= '0; cnt_r <= '0; st_valid_r <= 1'b0;
    end else begin
      if (st_valid_r && st_ready) st_valid_r <= 1'b0;
      if (lv_r && in_tready) begin
        if (cnt_nxt >= wn) begin
          st_r.sum <= sum_nxt; st_r.sq <= sq_nxt; st_r.cnt <= cnt_nxt;
          st_valid_r <= 1'b1;
          sum_r <= '0; sq_r <= '0; cnt_r <= '0;
        end else begin
          sum_r <= sum_nxt; sq_r <= sq_nxt; cnt_r <= cnt_nxt;
        end
      end
    end
  end

  assign st_valid = st_valid_r;
  assign st_data = st_r;
endmodule

### sv/bcda_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcda_fifo: two-entry queue between front and back ends
// ----------------------------------------------------------------------------
module bcda_fifo
  import bcda_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  win_stat_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output win_stat_t rd_data
);
  win_stat_t mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= !wp_r;
      if (rd_valid && rd_ready) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

### sv/bcda_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcda_finish: back end
// Sequencer over a shared restoring divider and square-root unit; computes
// mean, deviation, two smoothsteps and the amplitude.
// ----------------------------------------------------------------------------
module bcda_finish
  import bcda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        st_valid,
  output logic        st_ready,
  input  win_stat_t   st_data,
  input  logic [15:0] flat_level,
  input  logic [15:0] edge_level,
  input  logic [15:0] headroom_span,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata
);
  localparam int DW = 56;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_SQ   = 13'b0000000000010,
    S_D1   = 13'b0000000000100,
    S_D2   = 13'b0000000001000,
    S_D3   = 13'b0000000010000,
    S_SQRT = 13'b0000000100000,
    S_SM1  = 13'b0000001000000,
    S_T1   = 13'b0000010000000,
    S_SM2  = 13'b0000100000000,
    S_T2   = 13'b0001000000000,
    S_AMP  = 13'b0010000000000,
    S_OUT  = 13'b0100000000000,
    S_D0   = 13'b1000000000000
  } state_t;

  state_t state_r;
  win_stat_t st_r;
  logic [DW-1:0] num_r, rem_r, den_r;
  logic [5:0]    it_r;
  logic [15:0]   m_r, sd_r;
  logic [16:0]   t_r, flat_r, room_r;
  logic [55:0]   ss_r;
  logic [33:0]   tt_r;
  logic [15:0]   amp_r;
  logic          phase_r;
  logic [31:0]   sq_v_r;
  logic [31:0]   sres_r;
  logic [DW:0]   trial;
  logic [DW-1:0] rsh;
  logic [16:0]   near;
  logic [15:0]   lo, hi, v;
  logic [50:0]   poly;
  logic [32:0]   amp_w;

  assign st_ready   = state_r == S_IDLE;
  assign out_tvalid = (state_r == S_OUT) && (it_r == 6'd0);
  assign out_tdata  = amp_r;

  // one divider bit per cycle
  assign rsh   = {rem_r[DW-2:0], num_r[DW-1]};
  assign trial = {1'b0, rsh} - {1'b0, den_r};

  assign near = (m_r < 16'd65280 - m_r) ? {1'b0, m_r} : {1'b0, 16'd65280 - m_r};
  always_comb begin
    if (!phase_r) begin lo = flat_level; hi = edge_level; v = sd_r; end
    else begin lo = 16'd0; hi = headroom_span; v = near[15:0]; end
  end
  assign poly  = 51'(tt_r) * 51'(18'd196608 - {t_r, 1'b0});
  assign amp_w = (33'(flat_r) * 33'(room_r)) >> 16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (st_valid) begin
          st_r <= st_data; phase_r <= 1'b0; state_r <= S_SQ;
        end
        // S*S, then floor(S*S/n)
        S_SQ: begin
          ss_r <= 56'(st_r.sum) * 56'(st_r.sum);
          state_r <= S_D0;
        end
        S_D0: begin
          num_r <= ss_r; den_r <= DW'(st_r.cnt); rem_r <= '0; it_r <= '0;
          state_r <= S_D1;
        end
        S_D1, S_D2, S_D3: begin
          if (!trial[DW]) rem_r <= trial[DW-1:0]; else rem_r <= rsh;
          num_r <= {num_r[DW-2:0], !trial[DW]};
          it_r <= it_r + 1'b1;
          if (it_r == 6'(DW - 1)) begin
            unique case (state_r)
              S_D1: begin
                num_r <= DW'(st_r.sq) - {num_r[DW-2:0], !trial[DW]};
                rem_r <= '0; it_r <= '0; state_r <= S_D2;
              end
              S_D2: begin
                ss_r <= {num_r[DW-2:0], !trial[DW]};
                num_r <= DW'(st_r.sum); rem_r <= '0; it_r <= '0; state_r <= S_D3;
              end
              default: begin
                m_r <= 16'({num_r[DW-2:0], !trial[DW]});
                sq_v_r <= 32'(ss_r); sres_r <= '0; it_r <= '0; state_r <= S_SQRT;
              end
            endcase
          end
        end
        // bit-pair square root, 16 steps
        S_SQRT: begin
          if (sq_v_r >= (sres_r | (32'd1 << (6'd30 - {it_r[4:0], 1'b0})))) begin
            sq_v_r <= sq_v_r - (sres_r | (32'd1 << (6'd30 - {it_r[4:0], 1'b0})));
            sres_r <= (sres_r >> 1) | (32'd1 << (6'd30 - {it_r[4:0], 1'b0}));
          end else begin
            sres_r <= sres_r >> 1;
          end
          it_r <= it_r + 1'b1;
          if (it_r == 6'd15) state_r <= S_SM1;
        end
        // smoothstep parameter T
        S_SM1: begin
          if (phase_r == 1'b0 && it_r == 6'd16) sd_r <= sres_r[15:0];
          if (it_r == 6'd16) begin
            it_r <= '0;
          end else if (hi <= lo) begin
            t_r <= (v < lo) ? 17'd0 : 17'd65536; tt_r <= '0;
            state_r <= S_T2;
          end else if (v <= lo) begin
            t_r <= '0; state_r <= S_T1;
          end else if (v >= hi) begin
            t_r <= 17'd65536; state_r <= S_T1;
          end else begin
            // 32-bit dividend left-aligned, 32 quotient steps
            num_r <= {v - lo, 16'd0, 24'd0}; den_r <= DW'(hi - lo);
            rem_r <= '0; it_r <= 6'(DW - 32); state_r <= S_SM2;
          end
        end
        S_SM2: begin
          if (!trial[DW]) rem_r <= trial[DW-1:0]; else rem_r <= rsh;
          num_r <= {num_r[DW-2:0], !trial[DW]};
          it_r <= it_r + 1'b1;
          if (it_r == 6'(DW - 1)) begin
            t_r <= 17'({num_r[DW-2:0], !trial[DW]}); state_r <= S_T1;
          end
        end
        S_T1: begin
          tt_r <= 34'(t_r) * 34'(t_r); state_r <= S_AMP; it_r <= 6'd1;
        end
        S_T2, S_AMP: begin
          if (state_r == S_AMP && it_r == 6'd1) begin
            it_r <= '0;
          end else begin
            if (!phase_r) begin
              flat_r <= 17'd65536 - ((state_r == S_T2) ? t_r : 17'(poly >> 32));
              phase_r <= 1'b1; it_r <= 6'd16; state_r <= S_SM1;
            end else begin
              room_r <= (state_r == S_T2) ? t_r : 17'(poly >> 32);
              state_r <= S_OUT; it_r <= 6'd2;
            end
          end
        end
        S_OUT: begin
          if (it_r != 6'd0) begin
            if (it_r == 6'd2) amp_r <= (amp_w > 33'd65535) ? 16'hFFFF : amp_w[15:0];
            it_r <= it_r - 1'b1;
          end else if (out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### sv/block_contrast_dither_amplitude.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_contrast_dither_amplitude: dither amplitude from window statistics
//
//  channel | dir | tdata fields (low bit first)
//  in_     | in  | red[7:0], green[15:8], blue[23:16]
//  out_    | out | amplitude[15:0]
//  cfg_    | in  | index 0..4, data 16 bits
//
// Pixels enter one per cycle, while intake is not stalled, into a two-stage
// accumulator. A finished window goes through a two-entry queue to the finish
// sequencer, which takes one window at a time (three 56-step divides, a
// 16-step root, one 32-step divide per smoothstep). Reset is synchronous and
// clears all sums. Intake stalls only when a window completes while the queue
// is full.
// ----------------------------------------------------------------------------
module block_contrast_dither_amplitude
  import bcda_pkg::*;
#(
  parameter int MAX_BLOCK_SIDE = MAX_BLOCK_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red, green, blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // amplitude
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [6:0]  bw_r, bh_r;
  logic [15:0] flat_r, edge_r, head_r;
  logic        a_v, a_r, f_v, f_r;
  win_stat_t   a_d, f_d;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r <= 7'd8; bh_r <= 7'd8;
      flat_r <= 16'd512; edge_r <= 16'd4096; head_r <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BW:   bw_r <= cfg_data[6:0];
        REG_BH:   bh_r <= cfg_data[6:0];
        REG_FLAT: flat_r <= cfg_data;
        REG_EDGE: edge_r <= cfg_data;
        REG_HEAD: head_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bcda_accum #(.MAX_BLOCK_SIDE(MAX_BLOCK_SIDE)) u_accum (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .block_width(bw_r), .block_height(bh_r),
    .st_valid(a_v), .st_ready(a_r), .st_data(a_d)
  );

  bcda_fifo u_fifo (
    .clk, .rst_n, .wr_valid(a_v), .wr_ready(a_r), .wr_data(a_d),
    .rd_valid(f_v), .rd_ready(f_r), .rd_data(f_d)
  );

  bcda_finish u_finish (
    .clk, .rst_n, .st_valid(f_v), .st_ready(f_r), .st_data(f_d),
    .flat_level(flat_r), .edge_level(edge_r), .headroom_span(head_r),
    .out_tvalid, .out_tready, .out_tdata
  );
endmodule

### test/bcda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcda_checker: amplitude predictor and scoreboard
// Watches the pixel, result and register channels, predicts each window's
// dither amplitude in fixed point and compares it with what the block emits.
// ----------------------------------------------------------------------------
module bcda_checker
  import bcda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          amp_seen
);

  logic [6:0]  side_w, side_h;
  logic [15:0] flat_lvl, edge_lvl, head_span;
  logic [63:0] acc_sum, acc_sq, acc_cnt;
  logic [15:0] amp_queue[$];

  function automatic logic [63:0] win_side(logic [6:0] s);
    if (s < 3) return 3;
    if (s > MAX_BLOCK_SIDE_DEF) return MAX_BLOCK_SIDE_DEF;
    return s;
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // smoothstep curve, 65536 is 1.0
  function automatic logic [63:0] ramp(logic [63:0] lo, logic [63:0] hi, logic [63:0] v);
    logic [63:0] t;
    if (hi <= lo) return (v < lo) ? 64'd0 : 64'd65536;
    if (v <= lo) t = 0;
    else if (v >= hi) t = 65536;
    else t = ((v - lo) << 16) / (hi - lo);
    return (t * t * (64'd196608 - 2 * t)) >> 32;
  endfunction

  function automatic logic [15:0] window_amp();
    logic [63:0] n, m, vr, sd, nr, fl, rm, a;
    n = acc_cnt;
    m = acc_sum / n;
    vr = (acc_sq - (acc_sum * acc_sum) / n) / n;
    sd = int_root(vr);
    nr = (m < 65280 - m) ? m : 65280 - m;
    fl = 65536 - ramp(flat_lvl, edge_lvl, sd);
    rm = ramp(0, head_span, nr);
    a = (fl * rm) >> 16;
    return (a > 65535) ? 16'hFFFF : a[15:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [63:0] luma;
    if (!rst_n) begin
      side_w <= 8; side_h <= 8;
      flat_lvl <= 512; edge_lvl <= 4096; head_span <= 4096;
      acc_sum = 0; acc_sq = 0; acc_cnt = 0;
      amp_queue.delete();
      fail_count = 0; pending = 0; amp_seen = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_BW:   side_w <= cfg_data[6:0];
          REG_BH:   side_h <= cfg_data[6:0];
          REG_FLAT: flat_lvl <= cfg_data;
          REG_EDGE: edge_lvl <= cfg_data;
          REG_HEAD: head_span <= cfg_data;
          default: ;
        endcase
      end
      // accepted pixel request
      if (in_tvalid && in_tready) begin
        luma = 77 * in_tdata[7:0] + 150 * in_tdata[15:8] + 29 * in_tdata[23:16];
        acc_sum += luma;
        acc_sq += luma * luma;
        acc_cnt += 1;
        if (acc_cnt >= win_side(side_w) * win_side(side_h)) begin
          amp_queue.push_back(window_amp());
          acc_sum = 0; acc_sq = 0; acc_cnt = 0;
        end
      end
      // result request
      if (out_tvalid && out_tready) begin
        amp_seen++;
        if (amp_queue.size() == 0)
          report_mismatch($sformatf("unexpected amplitude %0d", out_tdata));
        else if (amp_queue[0] !== out_tdata) begin
          report_mismatch($sformatf("amplitude %0d, expected %0d", out_tdata,
                                    amp_queue[0]));
          void'(amp_queue.pop_front());
        end else
          void'(amp_queue.pop_front());
      end
      pending = amp_queue.size();
    end
  end

endmodule

### test/tb_block_contrast_dither_amplitude.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_contrast_dither_amplitude: stimulus and verdict
// Feeds pixel windows of several sizes and thresholds, with random gaps and
// output stalls, and lets bcda_checker compare the amplitudes.
// ----------------------------------------------------------------------------
module tb_block_contrast_dither_amplitude;
  import bcda_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = 0;   // red, green, blue
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;      // amplitude
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [15:0] cfg_data = 0;
  int          fail_count, pending, amp_seen;
  int          pixels_sent = 0;
  bit          calm = 0;
  bit          hold_off = 0;

  always #5 clk = ~clk;

  block_contrast_dither_amplitude uut (.*);
  bcda_checker chk (.*);

  // window geometry of the current phase
  int cur_w = 8, cur_h = 8;

  // receiver: random stall bursts, one long hold-off counted here
  initial begin
    int k;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 0;
        repeat (2000) @(negedge clk);
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_tready <= 0;
        k = $urandom_range(1, 16);
        repeat (k - 1) @(negedge clk);
      end else out_tready <= 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // idle wait once every window result is in, plus the finish latency
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic send_pixel(logic [23:0] px);
    int k;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 0;
      k = $urandom_range(1, 16);
      repeat (k) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  // kind: 0 random, 1 flat, 2 two-level edge, 3 gentle noise
  task automatic send_window(int kind);
    logic [23:0] base, px;
    int n;
    n = ((cur_w < 3) ? 3 : (cur_w > 64 ? 64 : cur_w)) *
        ((cur_h < 3) ? 3 : (cur_h > 64 ? 64 : cur_h));
    base = 24'($urandom);
    for (int i = 0; i < n; i++) begin
      case (kind)
        1: px = base;
        2: px = ($urandom_range(0, 1) != 0) ? base : ~base;
        3: px = base ^ (24'($urandom) & 24'h070707);
        default: px = 24'($urandom);
      endcase
      send_pixel(px);
    end
  endtask

  task automatic set_size(int w, int h);
    cur_w = w; cur_h = h;
    write_reg(REG_BW, 16'(w));
    write_reg(REG_BH, 16'(h));
  endtask

  initial begin
    int phase;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: smallest window, extremes of the pixel fields
    set_size(1, 2);
    send_pixel(24'h000000); send_pixel(24'hFFFFFF); send_pixel(24'h0000FF);
    send_pixel(24'h00FF00); send_pixel(24'hFF0000); send_pixel(24'h808080);
    send_pixel(24'h7F7F7F); send_pixel(24'hAA55AA); send_pixel(24'h55AA55);
    for (int i = 0; i < 9; i++) send_pixel(24'h000000);
    in_tvalid <= 0;
    drain();
    // zero headroom, hard step thresholds
    write_reg(REG_HEAD, 16'd0);
    write_reg(REG_FLAT, 16'h1000); write_reg(REG_EDGE, 16'h0100);
    write_reg(3'd7, 16'hFFFF);
    send_window(1);
    in_tvalid <= 0;
    drain();
    // size change mid-window: count already past the new size
    set_size(8, 8);
    for (int i = 0; i < 20; i++) send_pixel(24'($urandom));
    in_tvalid <= 0;
    set_size(2, 2);
    send_pixel(24'h123456);
    in_tvalid <= 0;
    drain();

    // random phases over sizes and thresholds
    phase = 0;
    while (pixels_sent < 1650) begin
      case (phase % 6)
        0: set_size(3, 3);
        1: set_size($urandom_range(1, 6), $urandom_range(1, 6));
        2: set_size(127, 1);
        3: set_size(4, 5);
        default: set_size($urandom_range(1, 8), $urandom_range(1, 8));
      endcase
      case (phase % 4)
        0: begin write_reg(REG_FLAT, 16'd0); write_reg(REG_EDGE, 16'hFFFF);
                 write_reg(REG_HEAD, 16'hFFFF); end
        1: begin write_reg(REG_FLAT, 16'd512); write_reg(REG_EDGE, 16'd4096);
                 write_reg(REG_HEAD, 16'd4096); end
        2: begin write_reg(REG_FLAT, 16'($urandom)); write_reg(REG_EDGE, 16'($urandom));
                 write_reg(REG_HEAD, 16'($urandom)); end
        default: begin write_reg(REG_FLAT, 16'($urandom_range(0, 8192)));
                 write_reg(REG_EDGE, 16'($urandom_range(0, 8192)));
                 write_reg(REG_HEAD, 16'($urandom_range(0, 16384))); end
      endcase
      if (phase == 3) hold_off = 1;
      if (pixels_sent > 1400) calm = 1;
      for (int i = 0; i < 6; i++) send_window($urandom_range(0, 3));
      in_tvalid <= 0;
      drain();
      phase++;
    end

    $display("Covered %0d pixels, %0d window amplitudes, %0d phases of size and thresholds.",
             pixels_sent, amp_seen, phase);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
